// ===== src/fqs_pkg.sv =====
// fqs_pkg: shared types and constants for the searchable FIFO queue.
// Used by fqs_cell, fifo_queue_with_search and fqs_checker. No dependencies.

package fqs_pkg;

    localparam int unsigned DEPTH_DEF = 16;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned OCC_W    = 5;

    // opcodes
    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_SRCH = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } fsm_state_t;

    // broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic enq;        // store the new word in the first empty cell
        logic deq;        // every cell takes its upper neighbor's contents
        logic srch_load;  // every cell latches its own compare result
        logic srch_shift; // hit flags move one cell toward the top
    } cell_ctrl_t;

endpackage

// ===== src/fifo_queue_with_search.sv =====
// fifo_queue_with_search: FIFO of signed 32-bit words with newest-match search,
// built as a chain of fqs_cell instances. Depends on fqs_pkg and fqs_cell.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_opcode s_value        | in
//  result  | m_valid m_ready m_status m_data_out     | out
//          | m_found m_position m_occupancy          |
//
// Enqueue, dequeue and the unused opcode finish in the accepting cycle; the
// result register is loaded at that edge. During a search scan, hit flags
// walk the cell chain one cell per cycle toward the top cell, and the first
// flag reaching the top marks the newest match.
// s_ready is low while a search scans, or while an untaken result blocks the
// result register (it rises in the same cycle the result transfer happens).
// Reset (aresetn low, synchronous) empties the queue; no clearing pass.

module fifo_queue_with_search #(
    parameter int unsigned DEPTH = fqs_pkg::DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [fqs_pkg::OP_W-1:0]     s_opcode,
    input  logic signed [fqs_pkg::DATA_W-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [fqs_pkg::STATUS_W-1:0] m_status,
    output logic signed [fqs_pkg::DATA_W-1:0] m_data_out,
    output logic                         m_found,
    output logic [fqs_pkg::POS_W-1:0]    m_position,
    output logic [fqs_pkg::OCC_W-1:0]    m_occupancy
);
    import fqs_pkg::*;

    // count holds 0..DEPTH, scan step 0..DEPTH-1
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned SW   = $clog2(DEPTH);
    localparam int unsigned SUMW = (CW + 1 > POS_W) ? CW + 1 : POS_W;
    localparam int unsigned CXW  = (CW > OCC_W) ? CW : OCC_W;

    fsm_state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] step_reg, step_next;

    logic          m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]   data_out_reg, data_out_next;
    logic                found_reg, found_next;
    logic [POS_W-1:0]    position_reg, position_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;

    logic          accept;
    logic          full, empty;
    logic          scan_done;
    logic          res_load;
    cell_ctrl_t    ctrl;

    logic [SUMW-1:0] pos_sum;
    logic [CXW-1:0]  occ_ext;

    // cell chain: index 0 holds the oldest word, filled run grows upward
    logic [DATA_W-1:0] cell_data  [DEPTH];
    logic              cell_valid [DEPTH];
    logic              cell_hit   [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic              prev_v;
            logic [DATA_W-1:0] up_d;
            logic              up_v;
            logic              dn_h;

            if (gi == 0) begin : g_bot
                assign prev_v = 1'b1;
                assign dn_h   = 1'b0;
            end else begin : g_mid
                assign prev_v = cell_valid[gi-1];
                assign dn_h   = cell_hit[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_top
                assign up_d = '0;
                assign up_v = 1'b0;
            end else begin : g_low
                assign up_d = cell_data[gi+1];
                assign up_v = cell_valid[gi+1];
            end

            fqs_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .wr_value   (s_value),
                .prev_valid (prev_v),
                .up_data    (up_d),
                .up_valid   (up_v),
                .dn_hit     (dn_h),
                .data       (cell_data[gi]),
                .valid      (cell_valid[gi]),
                .hit        (cell_hit[gi])
            );
        end
    endgenerate

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // scan ends when a hit reaches the top cell or every cell has passed it
    assign scan_done = cell_hit[DEPTH-1] || (step_reg == SW'(DEPTH - 1));

    // a hit from cell i reaches the top after DEPTH-1-i shifts;
    // its distance from the newest word is count-1-i
    assign pos_sum = SUMW'(count_reg) + SUMW'(step_reg) - SUMW'(DEPTH);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (s_opcode == OP_SRCH)) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready         = 1'b0;
        ctrl            = '0;
        res_load        = 1'b0;
        step_next       = step_reg;
        status_next     = ST_OK;
        data_out_next   = '0;
        found_next      = 1'b0;
        position_next   = '0;
        count_next      = count_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
            end
            S_SCAN: begin
                ctrl.srch_shift = !scan_done;
                step_next       = step_reg + SW'(1);
                if (scan_done) begin
                    res_load      = 1'b1;
                    found_next    = cell_hit[DEPTH-1];
                    position_next = cell_hit[DEPTH-1] ? pos_sum[POS_W-1:0] : '0;
                end
            end
            default: s_ready = 1'b0;
        endcase

        if (accept) begin
            step_next = '0;
            unique case (s_opcode)
                OP_ENQ: begin
                    res_load = 1'b1;
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        ctrl.enq   = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_DEQ: begin
                    res_load = 1'b1;
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        ctrl.deq      = 1'b1;
                        data_out_next = cell_data[0];
                        count_next    = count_reg - CW'(1);
                    end
                end
                OP_SRCH: begin
                    ctrl.srch_load = 1'b1;
                end
                OP_NOP: begin
                    res_load = 1'b1;
                end
                default: res_load = 1'b1;
            endcase
        end
    end

    assign accept  = s_valid && s_ready;
    assign occ_ext = CXW'(count_next);
    assign occ_next = occ_ext[OCC_W-1:0];

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (res_load) begin
            status_reg   <= status_next;
            data_out_reg <= data_out_next;
            found_reg    <= found_next;
            position_reg <= position_next;
            occ_reg      <= occ_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_data_out  = data_out_reg;
    assign m_found     = found_reg;
    assign m_position  = position_reg;
    assign m_occupancy = occ_reg;

endmodule

// ===== src/fqs_cell.sv =====
// fqs_cell: one storage cell of the queue chain: word, valid flag, compare
// and hit flag. Depends on fqs_pkg.

module fqs_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fqs_pkg::cell_ctrl_t        ctrl,
    input  logic [fqs_pkg::DATA_W-1:0] wr_value,
    input  logic                       prev_valid,
    input  logic [fqs_pkg::DATA_W-1:0] up_data,
    input  logic                       up_valid,
    input  logic                       dn_hit,
    output logic [fqs_pkg::DATA_W-1:0] data,
    output logic                       valid,
    output logic                       hit
);
    import fqs_pkg::*;

    logic [DATA_W-1:0] data_reg, data_next;
    logic              valid_reg, valid_next;
    logic              hit_reg, hit_next;
    logic              wr_here;

    // first empty cell above the filled run takes the new word
    assign wr_here = ctrl.enq && !valid_reg && prev_valid;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.deq) begin
            data_next  = up_data;
            valid_next = up_valid;
        end else if (wr_here) begin
            data_next  = wr_value;
            valid_next = 1'b1;
        end
    end

    always_comb begin
        hit_next = hit_reg;
        if (ctrl.srch_load) begin
            hit_next = valid_reg && (data_reg == wr_value);
        end else if (ctrl.srch_shift) begin
            hit_next = dn_hit;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign hit   = hit_reg;

endmodule

// ===== src/fqs_checker.sv =====
// fqs_checker: port-level assertions for fifo_queue_with_search, with bind.
// Depends on fqs_pkg and the top level's port list.

module fqs_checker #(
    parameter int unsigned DEPTH = fqs_pkg::DEPTH_DEF
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [fqs_pkg::STATUS_W-1:0] m_status,
    input logic [fqs_pkg::DATA_W-1:0]   m_data_out,
    input logic                         m_found,
    input logic [fqs_pkg::POS_W-1:0]    m_position,
    input logic [fqs_pkg::OCC_W-1:0]    m_occupancy
);
    import fqs_pkg::*;

    localparam int unsigned CXW = ($clog2(DEPTH + 1) > OCC_W) ? $clog2(DEPTH + 1) : OCC_W;
    localparam logic [CXW-1:0] FULL_EXT = CXW'(DEPTH);
    localparam logic [OCC_W-1:0] FULL_OCC = FULL_EXT[OCC_W-1:0];

    // a rejected enqueue only happens with the queue at capacity
    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL) |-> (m_occupancy == FULL_OCC))
        else $error("full status with occupancy below capacity");

    // a rejected dequeue leaves an empty queue and returns zero
    a_empty_res: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_EMPTY) |-> (m_occupancy == '0) && (m_data_out == '0))
        else $error("empty status with nonzero occupancy or data");

    // a hit comes only from a search: ok status, no dequeued word
    a_found_res: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> (m_status == ST_OK) && (m_data_out == '0))
        else $error("found flag on a result that is not a search");

    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> (m_position == '0))
        else $error("position nonzero without a match");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out) && $stable(m_occupancy))
        else $error("result changed while stalled");

endmodule

bind fifo_queue_with_search fqs_checker #(.DEPTH(DEPTH)) u_fqs_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_data_out  (m_data_out),
    .m_found     (m_found),
    .m_position  (m_position),
    .m_occupancy (m_occupancy)
);
